[hw/rtl/scr_fire_pkg.sv]
// shared types, constants and register codes for the scr firing control block
package scr_fire_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int PULSE_BITS_DEF = 12;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_STEP   = 3'd4;

	localparam logic [15:0] MIN_DELAY_RST    = 16'd10666;
	localparam logic [15:0] MAX_DELAY_RST    = 16'd20952;
	localparam logic [15:0] SECOND_DELAY_RST = 16'd10467;
	localparam logic [11:0] PULSE_WIDTH_RST  = 12'd762;
	localparam logic [9:0]  DELAY_STEP_RST   = 10'd100;

	localparam logic [31:0] FIRING_DELAY_RST = 32'd15952;
	localparam logic [32:0] RAISE_MARGIN     = 33'd50;
	localparam logic [32:0] LOWER_MARGIN     = 33'd200;

	typedef struct packed {
		logic zero_cross_a;
		logic zero_cross_b;
		logic zero_cross_c;
		logic raise_delay;
		logic lower_delay;
	} in_item_t;

	typedef struct packed {
		logic        gate_a_upper;
		logic        gate_a_lower;
		logic        gate_b_upper;
		logic        gate_b_lower;
		logic        gate_c_upper;
		logic        gate_c_lower;
		logic [15:0] delay_now;
	} out_item_t;

	typedef struct packed {
		logic upper;
		logic lower;
	} gate_pair_t;

endpackage

[hw/rtl/scr_fire_phase.sv]
// one phase: firing countdown, gate pulse counter and gate drive
module scr_fire_phase import scr_fire_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF,
	parameter int PULSE_BITS = PULSE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  zero_cross,
	input  logic [TIMER_BITS-1:0] firing_delay,
	input  logic [15:0]           second_delay,
	input  logic [11:0]           pulse_width,
	output gate_pair_t            gate
);

	logic [TIMER_BITS-1:0] countdown_q, countdown_d;
	logic                  armed_q, armed_d;
	logic                  first_q, first_d;
	logic [PULSE_BITS-1:0] pulse_q, pulse_d;
	logic                  is_lower_q, is_lower_d;

	logic [31:0]           second_ext;
	logic [31:0]           width_ext;
	logic [PULSE_BITS-1:0] pulse_dec;
	logic                  pulse_on;

	assign second_ext = {16'd0, second_delay};
	assign width_ext  = {20'd0, pulse_width};
	assign pulse_dec  = (pulse_q != '0) ? pulse_q - PULSE_BITS'(1) : pulse_q;

	always_comb begin
		countdown_d = countdown_q;
		armed_d     = armed_q;
		first_d     = first_q;
		pulse_d     = pulse_dec;
		is_lower_d  = is_lower_q;
		priority if (zero_cross) begin
			countdown_d = firing_delay;
			armed_d     = 1'b1;
		end else if (!armed_q) begin
		end else if (countdown_q > TIMER_BITS'(1)) begin
			countdown_d = countdown_q - TIMER_BITS'(1);
		end else if (first_q) begin
			pulse_d     = width_ext[PULSE_BITS-1:0];
			is_lower_d  = 1'b0;
			countdown_d = second_ext[TIMER_BITS-1:0];
			first_d     = 1'b0;
		end else begin
			pulse_d     = width_ext[PULSE_BITS-1:0];
			is_lower_d  = 1'b1;
			countdown_d = '0;
			armed_d     = 1'b0;
			first_d     = 1'b1;
		end
	end

	assign pulse_on   = pulse_d != '0;
	assign gate.upper = pulse_on && !is_lower_d;
	assign gate.lower = pulse_on && is_lower_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			armed_q     <= 1'b0;
			first_q     <= 1'b1;
			pulse_q     <= '0;
			is_lower_q  <= 1'b0;
		end else if (advance) begin
			countdown_q <= countdown_d;
			armed_q     <= armed_d;
			first_q     <= first_d;
			pulse_q     <= pulse_d;
			is_lower_q  <= is_lower_d;
		end
	end

endmodule

[hw/rtl/scr_fire_delay.sv]
// firing delay register with guarded raise and lower steps
module scr_fire_delay import scr_fire_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  raise_req,
	input  logic                  lower_req,
	input  logic [15:0]           min_delay,
	input  logic [15:0]           max_delay,
	input  logic [9:0]            delay_step,
	output logic [TIMER_BITS-1:0] delay_cur,
	output logic [TIMER_BITS-1:0] delay_next
);

	logic [TIMER_BITS-1:0] delay_q;
	logic [TIMER_BITS-1:0] delay_raised;
	logic [32:0]           cur_ext;
	logic [32:0]           raised_ext;
	logic [32:0]           step_ext;
	logic [32:0]           sum;
	logic                  raise_ok;
	logic                  lower_ok;

	assign cur_ext  = {{(33-TIMER_BITS){1'b0}}, delay_q};
	assign step_ext = {23'd0, delay_step};
	assign sum      = cur_ext + step_ext;
	assign raise_ok = raise_req && (cur_ext + RAISE_MARGIN < {17'd0, max_delay});

	always_comb begin
		delay_raised = delay_q;
		if (raise_ok) begin
			delay_raised = (sum[32:TIMER_BITS] != '0) ? '1 : sum[TIMER_BITS-1:0];
		end
	end

	assign raised_ext = {{(33-TIMER_BITS){1'b0}}, delay_raised};
	assign lower_ok   = lower_req && (raised_ext > {17'd0, min_delay} + LOWER_MARGIN);

	always_comb begin
		delay_next = delay_raised;
		if (lower_ok) begin
			delay_next = (raised_ext > step_ext) ?
				TIMER_BITS'(raised_ext - step_ext) : '0;
		end
	end

	assign delay_cur = delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= FIRING_DELAY_RST[TIMER_BITS-1:0];
		end else if (advance) begin
			delay_q <= delay_next;
		end
	end

endmodule

[hw/rtl/scr_fire_out_buf.sv]
// result register with skid stage between the block and its consumer
module scr_fire_out_buf import scr_fire_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t result,
	output logic      busy,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      main_valid_q;
	out_item_t main_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      main_free;

	assign main_free = !main_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || load;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : result;
		end else if (load) begin
			skid_q <= result;
		end
	end

	assign busy      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

[hw/rtl/three_phase_scr_firing_control_unit.sv]
// top level of the three-phase scr firing control block
//
//  channel   direction  handshake            word
//  in        input      in_valid / in_stall  in_item_t, one timer tick
//  out       output     out_valid/out_stall  out_item_t, gates and delay
//  cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word in per cycle while in_stall is low, its result registered in the result register or the skid stage
// a skid stage behind the result register keeps input open for one stalled word
// in_stall rises only while the skid stage holds a word
// cfg_ready is always high, registers take their defaults at reset
// reset returns all phase state to idle and loads the default firing delay
module three_phase_scr_firing_control_unit import scr_fire_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF,
	parameter int PULSE_BITS = PULSE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	logic [15:0] min_delay_q;
	logic [15:0] max_delay_q;
	logic [15:0] second_delay_q;
	logic [11:0] pulse_width_q;
	logic [9:0]  delay_step_q;

	logic                  accept;
	logic                  buf_busy;
	logic [TIMER_BITS-1:0] delay_cur;
	logic [TIMER_BITS-1:0] delay_next;
	logic [31:0]           delay_ext;
	logic [2:0]            zero_cross;
	gate_pair_t            gates [3];
	out_item_t             result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q    <= MIN_DELAY_RST;
			max_delay_q    <= MAX_DELAY_RST;
			second_delay_q <= SECOND_DELAY_RST;
			pulse_width_q  <= PULSE_WIDTH_RST;
			delay_step_q   <= DELAY_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_DELAY:    min_delay_q    <= cfg_data;
				CFG_MAX_DELAY:    max_delay_q    <= cfg_data;
				CFG_SECOND_DELAY: second_delay_q <= cfg_data;
				CFG_PULSE_WIDTH:  pulse_width_q  <= cfg_data[11:0];
				CFG_DELAY_STEP:   delay_step_q   <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall   = buf_busy;
	assign accept     = in_valid && !in_stall;
	assign zero_cross = {in_data.zero_cross_c, in_data.zero_cross_b, in_data.zero_cross_a};

	for (genvar p = 0; p < 3; p++) begin : g_phase
		scr_fire_phase #(
			.TIMER_BITS(TIMER_BITS),
			.PULSE_BITS(PULSE_BITS)
		) u_phase (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (accept),
			.zero_cross   (zero_cross[p]),
			.firing_delay (delay_cur),
			.second_delay (second_delay_q),
			.pulse_width  (pulse_width_q),
			.gate         (gates[p])
		);
	end

	scr_fire_delay #(
		.TIMER_BITS(TIMER_BITS)
	) u_delay (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.raise_req  (in_data.raise_delay),
		.lower_req  (in_data.lower_delay),
		.min_delay  (min_delay_q),
		.max_delay  (max_delay_q),
		.delay_step (delay_step_q),
		.delay_cur  (delay_cur),
		.delay_next (delay_next)
	);

	assign delay_ext = {{(32-TIMER_BITS){1'b0}}, delay_next};

	always_comb begin
		result.gate_a_upper = gates[0].upper;
		result.gate_a_lower = gates[0].lower;
		result.gate_b_upper = gates[1].upper;
		result.gate_b_lower = gates[1].lower;
		result.gate_c_upper = gates[2].upper;
		result.gate_c_lower = gates[2].lower;
		result.delay_now    = delay_ext[15:0];
	end

	scr_fire_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.result    (result),
		.busy      (buf_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[sim/three_phase_scr_firing_control_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the three-phase scr firing control unit
module three_phase_scr_firing_control_unit_test;
	import scr_fire_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_DELAY_STEP + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam logic [15:0] RST_DELAY = FIRING_DELAY_RST[15:0];
	localparam logic [15:0] HALF_STEP = 16'd512;
	localparam logic [15:0] CLIMB_KNEE = TICK_MAX - 16'd1022;
	localparam int RAISE_GAP = int'(RAISE_MARGIN);
	localparam int LOWER_GAP = int'(LOWER_MARGIN);
	localparam int IDLE_PCT = 33;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_PHASE = 3;
	localparam int CALM_PHASE = 5;
	localparam int RANDOM_WORDS = 1450;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
	typedef enum {PROF_NARROW, PROF_CEILING, PROF_FLAT_GUARD, PROF_WILD} profile_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0] data;
		in_item_t w;
		int reps;
		bit typed;
		out_item_t res;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [15:0] m_min, m_max, m_second, m_delay;
	logic [11:0] m_pulse;
	logic [9:0] m_step;
	logic [15:0] m_count [3];
	bit m_armed [3];
	bit m_first [3];
	logic [11:0] m_pulse_left [3];
	bit m_pulse_lower [3];

	out_item_t due_outputs [$];
	tick_row_t tick_script [$];
	int mismatches = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	three_phase_scr_firing_control_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_firing_model();
		int p;
		m_min = MIN_DELAY_RST;
		m_max = MAX_DELAY_RST;
		m_second = SECOND_DELAY_RST;
		m_pulse = PULSE_WIDTH_RST;
		m_step = DELAY_STEP_RST;
		m_delay = RST_DELAY;
		for (p = 0; p < 3; p++) begin
			m_count[p] = '0;
			m_armed[p] = 1'b0;
			m_first[p] = 1'b1;
			m_pulse_left[p] = '0;
			m_pulse_lower[p] = 1'b0;
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		case (idx)
			CFG_MIN_DELAY: m_min = data;
			CFG_MAX_DELAY: m_max = data;
			CFG_SECOND_DELAY: m_second = data;
			CFG_PULSE_WIDTH: m_pulse = data[11:0];
			CFG_DELAY_STEP: m_step = data[9:0];
			default: ;
		endcase
	endfunction

	function automatic out_item_t predict_tick(in_item_t w);
		int p;
		logic [2:0] zc;
		logic [5:0] gates;
		logic [16:0] sum;
		zc = {w.zero_cross_c, w.zero_cross_b, w.zero_cross_a};
		for (p = 0; p < 3; p++) begin
			if (m_pulse_left[p] != 0)
				m_pulse_left[p]--;
			if (zc[p]) begin
				m_count[p] = m_delay;
				m_armed[p] = 1'b1;
			end else if (m_armed[p]) begin
				if (m_count[p] > 1) begin
					m_count[p]--;
				end else if (m_first[p]) begin
					m_pulse_left[p] = m_pulse;
					m_pulse_lower[p] = 1'b0;
					m_count[p] = m_second;
					m_first[p] = 1'b0;
				end else begin
					m_pulse_left[p] = m_pulse;
					m_pulse_lower[p] = 1'b1;
					m_count[p] = '0;
					m_armed[p] = 1'b0;
					m_first[p] = 1'b1;
				end
			end
			gates[5-2*p] = (m_pulse_left[p] != 0) && !m_pulse_lower[p];
			gates[4-2*p] = (m_pulse_left[p] != 0) && m_pulse_lower[p];
		end
		if (w.raise_delay && int'(m_delay) < int'(m_max) - RAISE_GAP) begin
			sum = {1'b0, m_delay} + m_step;
			m_delay = (sum > TICK_MAX) ? TICK_MAX : sum[15:0];
		end
		if (w.lower_delay && int'(m_delay) > int'(m_min) + LOWER_GAP)
			m_delay = (m_delay > m_step) ? m_delay - m_step : 16'd0;
		return {gates, m_delay};
	endfunction

	function automatic in_item_t tick_word(bit a, bit b, bit c, bit raise, bit lower);
		in_item_t w;
		w.zero_cross_a = a;
		w.zero_cross_b = b;
		w.zero_cross_c = c;
		w.raise_delay = raise;
		w.lower_delay = lower;
		return w;
	endfunction

	function automatic in_item_t rand_word(int zc_rate, int raise_pct, int lower_pct);
		return tick_word($urandom_range(zc_rate - 1) == 0, $urandom_range(zc_rate - 1) == 0,
			$urandom_range(zc_rate - 1) == 0, $urandom_range(99) < raise_pct,
			$urandom_range(99) < lower_pct);
	endfunction

	function automatic void add_word(in_item_t w, int reps, bit typed, logic [15:0] delay);
		tick_row_t r;
		r.kind = ROW_WORD;
		r.idx = '0;
		r.data = '0;
		r.w = w;
		r.reps = reps;
		r.typed = typed;
		r.res = {6'b000000, delay};
		tick_script.push_back(r);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		tick_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.w = '0;
		r.reps = 0;
		r.typed = 1'b0;
		r.res = '0;
		tick_script.push_back(r);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_word(in_item_t w, bit typed, out_item_t res);
		out_item_t guess;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		guess = predict_tick(w);
		due_outputs.push_back(typed ? res : guess);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic load_regs(logic [15:0] min_d, logic [15:0] max_d, logic [15:0] second_d,
		logic [15:0] pulse_w, logic [15:0] step);
		settle();
		write_reg(CFG_MIN_DELAY, min_d);
		write_reg(CFG_MAX_DELAY, max_d);
		write_reg(CFG_SECOND_DELAY, second_d);
		write_reg(CFG_PULSE_WIDTH, pulse_w);
		write_reg(CFG_DELAY_STEP, step);
		write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// drive the firing delay down near zero, or up to saturation
	task automatic steer(bit up);
		load_regs(16'd0, 16'd0, m_second, m_pulse, TICK_MAX);
		while (int'(m_delay) > LOWER_GAP)
			send_word(rand_word(40, 50, 100), 1'b0, '0);
		if (up) begin
			load_regs(TICK_MAX, TICK_MAX, m_second, m_pulse, HALF_STEP);
			while (m_delay < CLIMB_KNEE)
				send_word(rand_word(40, 100, 50), 1'b0, '0);
			load_regs(TICK_MAX, TICK_MAX, m_second, m_pulse, TICK_MAX);
			send_word(rand_word(40, 100, 50), 1'b0, '0);
		end
	endtask

	initial begin : timeout
		#2_000_000;
		$display("FAIL three_phase_scr_firing_control_unit");
		$finish;
	end

	initial begin : result_sink
		out_item_t want;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (due_outputs.size() == 0) begin
					$error("result word with nothing expected: %h", out_data);
					mismatches++;
				end else begin
					want = due_outputs.pop_front();
					check_field("gate_a_upper", 16'(want.gate_a_upper), 16'(out_data.gate_a_upper));
					check_field("gate_a_lower", 16'(want.gate_a_lower), 16'(out_data.gate_a_lower));
					check_field("gate_b_upper", 16'(want.gate_b_upper), 16'(out_data.gate_b_upper));
					check_field("gate_b_lower", 16'(want.gate_b_lower), 16'(out_data.gate_b_lower));
					check_field("gate_c_upper", 16'(want.gate_c_upper), 16'(out_data.gate_c_upper));
					check_field("gate_c_lower", 16'(want.gate_c_lower), 16'(out_data.gate_c_lower));
					check_field("delay_now", want.delay_now, out_data.delay_now);
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		profile_t prof;
		int phase, n, len, pick, zc_rate, raise_pct, lower_pct, random_words;
		phase = 0;
		random_words = 0;
		reset_firing_model();

		// defaults after reset
		add_word(tick_word(0, 0, 0, 0, 0), 1, 1'b1, RST_DELAY);
		add_word(tick_word(0, 0, 0, 1, 0), 1, 1'b1, RST_DELAY + 16'(DELAY_STEP_RST));
		add_word(tick_word(0, 0, 0, 0, 1), 1, 1'b1, RST_DELAY);
		add_word(tick_word(0, 0, 0, 1, 1), 1, 1'b1, RST_DELAY);
		// unused indexes are ignored
		add_cfg(CFG_SPARE_FIRST, TICK_MAX);
		add_cfg(CFG_SPARE_LAST, TICK_MAX);
		// largest step, lower down to zero and past it
		add_cfg(CFG_MIN_DELAY, 16'd0);
		add_cfg(CFG_DELAY_STEP, TICK_MAX);
		add_cfg(CFG_SECOND_DELAY, 16'd0);
		add_cfg(CFG_PULSE_WIDTH, 16'd3);
		add_word(tick_word(0, 0, 0, 0, 1), 16, 1'b0, '0);
		// zero load fires next tick, second gate restarts the pulse
		add_word(tick_word(1, 1, 1, 0, 0), 1, 1'b0, '0);
		add_word(tick_word(0, 0, 0, 0, 0), 2, 1'b0, '0);
		// zero pulse width gives no pulse
		add_cfg(CFG_PULSE_WIDTH, 16'd0);
		add_word(tick_word(1, 0, 0, 0, 0), 1, 1'b0, '0);
		add_word(tick_word(0, 0, 0, 0, 0), 2, 1'b0, '0);
		// crossing during a count reloads instead of firing
		add_word(tick_word(0, 1, 0, 0, 0), 2, 1'b0, '0);
		add_word(tick_word(0, 0, 0, 0, 0), 1, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		foreach (tick_script[i]) begin
			if (tick_script[i].kind == ROW_CFG) begin
				settle();
				write_reg(tick_script[i].idx, tick_script[i].data);
				cfg_valid <= 1'b0;
			end else begin
				repeat (tick_script[i].reps)
					send_word(tick_script[i].w, tick_script[i].typed, tick_script[i].res);
			end
		end

		while (random_words < RANDOM_WORDS) begin
			case (phase)
				0: prof = PROF_CEILING;
				1: prof = PROF_FLAT_GUARD;
				2: prof = PROF_WILD;
				default: begin
					pick = $urandom_range(9);
					prof = (pick < 7) ? PROF_NARROW : (pick == 7) ? PROF_CEILING :
						(pick == 8) ? PROF_FLAT_GUARD : PROF_WILD;
				end
			endcase
			case (prof)
				PROF_NARROW: begin
					steer(1'b0);
					load_regs(16'($urandom_range(30)), 16'($urandom_range(300)),
						16'($urandom_range(60)),
						($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(25, 1)),
						16'($urandom_range(40, 1)));
				end
				PROF_CEILING: begin
					steer(1'b1);
					load_regs($urandom_range(1) ? TICK_MAX : 16'($urandom), TICK_MAX, TICK_MAX,
						TICK_MAX, TICK_MAX);
				end
				PROF_FLAT_GUARD: begin
					steer(1'b0);
					load_regs(16'd0, 16'($urandom_range(49)), 16'($urandom_range(40)),
						16'($urandom_range(20)), 16'($urandom));
				end
				default: begin
					load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				end
			endcase
			calm = (phase == CALM_PHASE);
			zc_rate = $urandom_range(250, 15);
			raise_pct = $urandom_range(50, 2);
			lower_pct = $urandom_range(50, 2);
			len = $urandom_range(220, 120);
			for (n = 0; n < len; n++) begin
				if (phase == HOLD_PHASE && n == 60)
					hold_req = 1'b1;
				send_word(rand_word(zc_rate, raise_pct, lower_pct), 1'b0, '0);
				random_words++;
			end
			calm = 1'b0;
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("PASS three_phase_scr_firing_control_unit");
		end else begin
			$display("FAIL three_phase_scr_firing_control_unit");
		end
		$finish;
	end

endmodule
